// ===== hdl/htrm_pkg.sv =====
`timescale 1ns / 1ps

package htrm_pkg;

  localparam int TEMP_W  = 16;
  localparam int BAND_W  = 12;
  localparam int FAN_W   = 9;
  localparam int STEP_W  = 12;
  localparam int POWER_W = 16;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;
  // indoor arithmetic runs two bits wider than a temperature
  localparam int WIDE_W  = TEMP_W + 2;

  localparam logic [FAN_W-1:0] FAN_FULL = FAN_W'(256);

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_REFERENCE = 3'd0;
  localparam logic [IDX_W-1:0] REG_BAND      = 3'd1;
  localparam logic [IDX_W-1:0] REG_FAN       = 3'd2;
  localparam logic [IDX_W-1:0] REG_DRIFT     = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_DELTA = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_POWER = 3'd5;
  localparam logic [IDX_W-1:0] REG_INITIAL   = 3'd6;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_HEAT = 2'd1,
    MODE_COOL = 2'd2
  } mode_t;

  // settings the update logic works from, with the fan products ready
  typedef struct packed {
    logic signed [TEMP_W-1:0] reference_temp;
    logic [BAND_W-1:0]        band_width;
    logic [BAND_W-1:0]        drift_step;
    logic signed [TEMP_W-1:0] initial_temp;
    logic [STEP_W-1:0]        hvac_step;
    logic [POWER_W-1:0]       hvac_power;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] indoor_temp;
    mode_t                    mode;
  } room_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] indoor_temp;
    mode_t                    mode;
    logic [POWER_W-1:0]       power;
  } result_t;

  function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(signed'(17'sd32767));
    lo = -WIDE_W'(signed'(17'sd32768));
    if (v > hi) begin
      sat_temp = 16'sh7fff;
    end else if (v < lo) begin
      sat_temp = 16'sh8000;
    end else begin
      sat_temp = v[TEMP_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/hysteresis_thermostat_room_model_core.sv =====
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid/in_ready    op, outdoor_temp
// out      out_valid/out_ready  indoor_temp_out, hvac_mode, power_out
// cfg      cfg_write            cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready is high; a beat passes through the input
// register, then the drift/thermostat update into the result register, from which it
// can be taken.
// Room state updates when a beat leaves the input register for the result register.
// A stalled result holds the update; the input register still takes one beat.
// Reset restores register defaults, indoor temperature zero and mode off.

module hysteresis_thermostat_room_model_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [htrm_pkg::IDX_W-1:0]         cfg_index,
  input  logic [htrm_pkg::DATA_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic signed [htrm_pkg::TEMP_W-1:0] outdoor_temp,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [htrm_pkg::TEMP_W-1:0] indoor_temp_out,
  output logic [1:0]                         hvac_mode,
  output logic [htrm_pkg::POWER_W-1:0]       power_out
);
  import htrm_pkg::*;

  cfg_t    cfg;
  room_t   room;
  room_t   room_next;
  result_t result;
  result_t out_data;

  logic                     stage_valid;
  logic                     stage_op;
  logic signed [TEMP_W-1:0] stage_outdoor;
  logic                     advance;

  htrm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  htrm_update u_update (
    .cfg          (cfg),
    .op           (stage_op),
    .outdoor_temp (stage_outdoor),
    .room         (room),
    .room_next    (room_next),
    .result       (result)
  );

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid      <= 1'b0;
      out_valid        <= 1'b0;
      room.indoor_temp <= '0;
      room.mode        <= MODE_OFF;
    end else begin
      if (in_ready) stage_valid <= in_valid;
      if (advance) begin
        out_valid <= 1'b1;
        room      <= room_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_op      <= op;
      stage_outdoor <= outdoor_temp;
    end
    if (advance) out_data <= result;
  end

  assign indoor_temp_out = out_data.indoor_temp;
  assign hvac_mode       = out_data.mode;
  assign power_out       = out_data.power;

  // power is drawn only while heating or cooling
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (hvac_mode == MODE_OFF) |-> power_out == '0)
    else $error("power reported while off");

  // a waiting beat is never dropped while the result is stalled
  assert property (@(posedge clk) disable iff (rst)
    stage_valid && out_valid && !out_ready |=> stage_valid && out_valid)
    else $error("beat lost under stall");

  // result register tracks room state after each update
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_data.indoor_temp == room.indoor_temp && out_data.mode == room.mode)
    else $error("result out of step with room state");

  assert property (@(posedge clk)
    rst |=> !out_valid && !stage_valid)
    else $error("pipeline not empty after reset");

endmodule

// ===== hdl/htrm_cfg.sv =====
`timescale 1ns / 1ps

module htrm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [htrm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [htrm_pkg::DATA_W-1:0]    cfg_data,
  output htrm_pkg::cfg_t                 cfg
);
  import htrm_pkg::*;

  logic signed [TEMP_W-1:0] reference_temp;
  logic [BAND_W-1:0]        band_width;
  logic [FAN_W-1:0]         fan_level;
  logic [BAND_W-1:0]        drift_step;
  logic [STEP_W-1:0]        max_delta;
  logic [POWER_W-1:0]       max_power;
  logic signed [TEMP_W-1:0] initial_temp;

  logic [FAN_W-1:0]               fan_clamped;
  logic [STEP_W+FAN_W-1:0]        step_prod;
  logic [POWER_W+FAN_W-1:0]       power_prod;

  assign fan_clamped = (cfg_data[FAN_W-1:0] > FAN_FULL) ? FAN_FULL : cfg_data[FAN_W-1:0];
  assign step_prod   = (STEP_W+FAN_W)'(max_delta) * (STEP_W+FAN_W)'(fan_level);
  assign power_prod  = (POWER_W+FAN_W)'(max_power) * (POWER_W+FAN_W)'(fan_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_temp <= 16'sd5632;
      band_width     <= 12'd256;
      fan_level      <= FAN_FULL;
      drift_step     <= 12'd13;
      max_delta      <= 12'd26;
      max_power      <= 16'd2000;
      initial_temp   <= 16'sd5632;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_REFERENCE: reference_temp <= cfg_data;
          REG_BAND:      band_width     <= cfg_data[BAND_W-1:0];
          REG_FAN:       fan_level      <= fan_clamped;
          REG_DRIFT:     drift_step     <= cfg_data[BAND_W-1:0];
          REG_MAX_DELTA: max_delta      <= cfg_data[STEP_W-1:0];
          REG_MAX_POWER: max_power      <= cfg_data[POWER_W-1:0];
          REG_INITIAL:   initial_temp   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // fan products follow the registers directly, truncated to whole units
  always_comb begin
    cfg.reference_temp = reference_temp;
    cfg.band_width     = band_width;
    cfg.drift_step     = drift_step;
    cfg.initial_temp   = initial_temp;
    cfg.hvac_step      = step_prod[8 +: STEP_W];
    cfg.hvac_power     = power_prod[8 +: POWER_W];
  end

endmodule

// ===== hdl/htrm_update.sv =====
`timescale 1ns / 1ps

module htrm_update (
  input  htrm_pkg::cfg_t                   cfg,
  input  logic                             op,
  input  logic signed [htrm_pkg::TEMP_W-1:0] outdoor_temp,
  input  htrm_pkg::room_t                  room,
  output htrm_pkg::room_t                  room_next,
  output htrm_pkg::result_t                result
);
  import htrm_pkg::*;

  logic signed [WIDE_W-1:0] indoor_w;
  logic signed [WIDE_W-1:0] drift_w;
  logic signed [WIDE_W-1:0] ref_w;
  logic signed [WIDE_W-1:0] full_w;
  logic signed [WIDE_W-1:0] half_w;
  logic signed [WIDE_W-1:0] step_w;
  logic signed [TEMP_W-1:0] drifted;
  logic signed [WIDE_W-1:0] drifted_w;
  logic signed [TEMP_W-1:0] moved;
  mode_t                    mode_upd;

  assign indoor_w = WIDE_W'(room.indoor_temp);
  assign drift_w  = signed'(WIDE_W'(cfg.drift_step));
  assign ref_w    = WIDE_W'(cfg.reference_temp);
  assign full_w   = signed'(WIDE_W'(cfg.band_width));
  assign half_w   = signed'(WIDE_W'(cfg.band_width >> 1));
  assign step_w   = signed'(WIDE_W'(cfg.hvac_step));

  // drift toward outdoor; a tie drifts down
  assign drifted   = (outdoor_temp > room.indoor_temp) ? sat_temp(indoor_w + drift_w)
                                                       : sat_temp(indoor_w - drift_w);
  assign drifted_w = WIDE_W'(drifted);

  always_comb begin
    mode_upd = room.mode;
    if (drifted_w < ref_w - full_w) begin
      mode_upd = MODE_HEAT;
    end else if (drifted_w < ref_w - half_w) begin
      if (mode_upd == MODE_COOL) mode_upd = MODE_OFF;
    end
    if (drifted_w > ref_w + full_w) begin
      mode_upd = MODE_COOL;
    end else if (drifted_w > ref_w + half_w) begin
      if (mode_upd == MODE_HEAT) mode_upd = MODE_OFF;
    end
  end

  always_comb begin
    case (mode_upd)
      MODE_HEAT: moved = sat_temp(drifted_w + step_w);
      MODE_COOL: moved = sat_temp(drifted_w - step_w);
      default:   moved = drifted;
    endcase
  end

  always_comb begin
    if (op) begin
      room_next.indoor_temp = cfg.initial_temp;
      room_next.mode        = MODE_OFF;
      result.power          = '0;
    end else begin
      room_next.indoor_temp = moved;
      room_next.mode        = mode_upd;
      result.power          = (mode_upd == MODE_OFF) ? '0 : cfg.hvac_power;
    end
    result.indoor_temp = room_next.indoor_temp;
    result.mode        = room_next.mode;
  end

endmodule

// ===== test/room_thermostat_checker.sv =====
`timescale 1ns / 1ps

module room_thermostat_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [htrm_pkg::IDX_W-1:0]         cfg_index,
  input  logic [htrm_pkg::DATA_W-1:0]        cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               op,
  input  logic signed [htrm_pkg::TEMP_W-1:0] outdoor_temp,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [htrm_pkg::TEMP_W-1:0] indoor_temp_out,
  input  logic [1:0]                         hvac_mode,
  input  logic [htrm_pkg::POWER_W-1:0]       power_out,
  output int                                 errors,
  output int                                 outstanding
);
  import htrm_pkg::*;

  // shadow of the register file
  logic signed [TEMP_W-1:0] setpoint;
  logic [BAND_W-1:0]        band;
  logic [FAN_W-1:0]         fan;
  logic [BAND_W-1:0]        drift;
  logic [STEP_W-1:0]        hvac_max;
  logic [POWER_W-1:0]       watt_max;
  logic signed [TEMP_W-1:0] restart_temp;

  // room state
  logic signed [TEMP_W-1:0] room_temp;
  mode_t                    room_mode;

  result_t room_forecast[$];
  result_t want;
  result_t fresh;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic int clamp_temp(input int v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic result_t next_room_state(input logic restart,
                                              input logic signed [TEMP_W-1:0] outdoor);
    result_t            r;
    int                 t;
    int                 full;
    int                 half;
    int                 step;
    logic [POWER_W-1:0] watts;
    watts = '0;
    if (restart) begin
      room_temp = restart_temp;
      room_mode = MODE_OFF;
    end else begin
      full = int'(band);
      half = int'(band >> 1);
      step = (int'(hvac_max) * int'(fan)) >>> 8;
      // drift falls on a tie
      if (outdoor > room_temp) begin
        t = clamp_temp(int'(room_temp) + int'(drift));
      end else begin
        t = clamp_temp(int'(room_temp) - int'(drift));
      end
      if (t < int'(setpoint) - full) begin
        room_mode = MODE_HEAT;
      end else if (t < int'(setpoint) - half && room_mode == MODE_COOL) begin
        room_mode = MODE_OFF;
      end
      if (t > int'(setpoint) + full) begin
        room_mode = MODE_COOL;
      end else if (t > int'(setpoint) + half && room_mode == MODE_HEAT) begin
        room_mode = MODE_OFF;
      end
      if (room_mode == MODE_HEAT) begin
        t = clamp_temp(t + step);
      end else if (room_mode == MODE_COOL) begin
        t = clamp_temp(t - step);
      end
      if (room_mode != MODE_OFF) begin
        watts = POWER_W'((int'(watt_max) * int'(fan)) >>> 8);
      end
      room_temp = TEMP_W'(t);
    end
    r.indoor_temp = room_temp;
    r.mode        = room_mode;
    r.power       = watts;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      setpoint     = 16'sd5632;
      band         = 12'd256;
      fan          = FAN_FULL;
      drift        = 12'd13;
      hvac_max     = 12'd26;
      watt_max     = 16'd2000;
      restart_temp = 16'sd5632;
      room_temp    = '0;
      room_mode    = MODE_OFF;
      room_forecast.delete();
    end else begin
      // retire the output beat before predicting a new one
      if (out_valid && out_ready) begin
        if (room_forecast.size() == 0) begin
          $display("%0t: unexpected result: temp %0d mode %0d power %0d", $time,
                   indoor_temp_out, hvac_mode, power_out);
          errors++;
        end else begin
          want = room_forecast.pop_front();
          if (indoor_temp_out !== want.indoor_temp) begin
            $display("%0t: indoor temp expected %0d actual %0d", $time,
                     want.indoor_temp, indoor_temp_out);
            errors++;
          end
          if (hvac_mode !== want.mode) begin
            $display("%0t: hvac mode expected %0d actual %0d", $time, want.mode, hvac_mode);
            errors++;
          end
          if (power_out !== want.power) begin
            $display("%0t: power expected %0d actual %0d", $time, want.power, power_out);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh = next_room_state(op, outdoor_temp);
        room_forecast.insert(room_forecast.size(), fresh);
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_REFERENCE: setpoint = cfg_data;
          REG_BAND:      band = cfg_data[BAND_W-1:0];
          REG_FAN:       fan = (cfg_data[FAN_W-1:0] > FAN_FULL) ? FAN_FULL
                                                                 : cfg_data[FAN_W-1:0];
          REG_DRIFT:     drift = cfg_data[BAND_W-1:0];
          REG_MAX_DELTA: hvac_max = cfg_data[STEP_W-1:0];
          REG_MAX_POWER: watt_max = cfg_data;
          REG_INITIAL:   restart_temp = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = room_forecast.size();
  end

endmodule

// ===== test/hysteresis_thermostat_room_model_core_tb.sv =====
`timescale 1ns / 1ps

module hysteresis_thermostat_room_model_core_tb;
  import htrm_pkg::*;

  localparam int LIMIT = 200000;
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [IDX_W-1:0]         cfg_index;
  logic [DATA_W-1:0]        cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic                     op;
  logic signed [TEMP_W-1:0] outdoor_temp;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [TEMP_W-1:0] indoor_temp_out;
  logic [1:0]               hvac_mode;
  logic [POWER_W-1:0]       power_out;

  int   errors;
  int   outstanding;
  int   cycle_count = 0;
  logic calm;
  logic [DATA_W-1:0] setting [0:7];

  hysteresis_thermostat_room_model_core u_dut (.*);

  room_thermostat_checker u_checker (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 29);
  end

  task automatic send_item(input logic kind, input logic [TEMP_W-1:0] reading);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    outdoor_temp <= reading;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid and wait for every predicted beat to come back
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // the spare index is written too; the block must drop it
  task automatic apply_settings();
    setting[REG_SPARE] = DATA_W'($urandom);
    for (int i = 0; i <= REG_SPARE; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= setting[i];
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin
    int pick;
    rst          = 1'b1;
    calm         = 1'b0;
    in_valid     = 1'b0;
    op           = OP_TICK;
    outdoor_temp = '0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    out_ready    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, ticks before any restart, outdoor equal to indoor
    send_item(OP_TICK, 16'h7fff);
    send_item(OP_TICK, 16'h8000);
    send_item(OP_TICK, 16'h0000);
    send_item(OP_RESTART, 16'h7fff);
    send_item(OP_TICK, 16'd5632);
    send_item(OP_TICK, 16'd5632);
    send_item(OP_RESTART, 16'h0000);
    settle();

    // bottom of the range, fan write above full
    setting[REG_REFERENCE] = 16'h8000;
    setting[REG_BAND]      = 16'hffff;
    setting[REG_FAN]       = 16'h01ff;
    setting[REG_DRIFT]     = 16'hffff;
    setting[REG_MAX_DELTA] = 16'hffff;
    setting[REG_MAX_POWER] = 16'hffff;
    setting[REG_INITIAL]   = 16'h8000;
    apply_settings();
    send_item(OP_RESTART, 16'h0000);
    send_item(OP_TICK, 16'h8000);
    send_item(OP_TICK, 16'h8000);
    repeat (4) send_item(OP_TICK, 16'h7fff);
    repeat (2) send_item(OP_TICK, 16'h8000);
    settle();

    // top of the range, zero band, fan off
    setting[REG_REFERENCE] = 16'h7fff;
    setting[REG_BAND]      = 16'h0000;
    setting[REG_FAN]       = 16'h0000;
    setting[REG_MAX_DELTA] = 16'h0fff;
    setting[REG_INITIAL]   = 16'h7fff;
    apply_settings();
    send_item(OP_RESTART, 16'h8000);
    send_item(OP_TICK, 16'h7fff);
    send_item(OP_TICK, 16'h8000);
    send_item(OP_TICK, 16'h7fff);
    settle();

    setting[REG_FAN] = 16'h0100;
    apply_settings();
    send_item(OP_RESTART, 16'h0000);
    repeat (2) send_item(OP_TICK, 16'h7fff);
    settle();

    for (int phase = 0; phase < 9; phase++) begin
      calm = (phase == 4);
      if (phase % 3 == 2) begin
        for (int i = 0; i < REG_SPARE; i++) setting[i] = DATA_W'($urandom);
      end else begin
        // setpoint near the start point so the thermostat cycles
        setting[REG_REFERENCE] = DATA_W'($urandom_range(12000) - 6000);
        setting[REG_INITIAL]   = setting[REG_REFERENCE] + DATA_W'($urandom_range(2000))
                                 - DATA_W'(1000);
        setting[REG_BAND]      = DATA_W'($urandom_range(1024, 16));
        setting[REG_FAN]       = DATA_W'($urandom_range(300));
        setting[REG_DRIFT]     = DATA_W'($urandom_range(64, 1));
        setting[REG_MAX_DELTA] = DATA_W'($urandom_range(300));
        setting[REG_MAX_POWER] = DATA_W'($urandom);
      end
      apply_settings();
      send_item(OP_RESTART, TEMP_W'($urandom));
      for (int n = 0; n < 49; n++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          send_item(OP_RESTART, TEMP_W'($urandom));
        end else if (pick < 9) begin
          send_item(OP_TICK, 16'h7fff);
        end else if (pick < 14) begin
          send_item(OP_TICK, 16'h8000);
        end else if (pick < 57) begin
          send_item(OP_TICK, TEMP_W'(setting[REG_REFERENCE] + $urandom_range(4000) - 2000));
        end else begin
          send_item(OP_TICK, TEMP_W'($urandom));
        end
      end
      settle();
    end
    calm = 1'b0;

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
